### design/first_fit_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// first-fit block allocator: assertion macros
// clocked assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// assertion disabled while reset is held
`define FFBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// assertion checked at every edge, reset included
`define FFBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFBA_ASSERT(label, clk, rst_n, prop, msg)
`define FFBA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    // field widths
    localparam int ADDR_W = 20;
    localparam int SIZE_W = 20;
    localparam int CAP_W  = 21;
    localparam int NEED_W = CAP_W + 1;

    // heap layout
    localparam int              HEADER_BYTES = 24;
    localparam logic [CAP_W-1:0] CAP_LIMIT   = CAP_W'(1) << ADDR_W;
    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1048576);

    // block table depth default
    localparam int MAX_BLOCKS_DEF = 64;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    // one block table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] length;
        logic              is_free;
    } t_entry;

    // table access request
    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        t_entry wr_entry;
    } t_mem_cmd;

    // one result
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
    } t_result;

endpackage

`default_nettype wire

### design/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// block table memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_table
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int IDX_W = $clog2(MAX_BLOCKS)
) (
    input  wire logic             i_clk,
    input  wire t_mem_cmd         i_cmd,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    output t_entry                o_rd_data
);

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_cmd.wr_entry;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// command sequencer: scans the block table, updates it and builds results
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_macros.svh"

module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int IDX_W = $clog2(MAX_BLOCKS),
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command in
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_cmd,
    input  wire logic [SIZE_W-1:0] i_req_size,
    input  wire logic [ADDR_W-1:0] i_address,
    // heap size register
    input  wire logic [CAP_W-1:0]  i_heap_cap,
    // result out
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    // block table
    output t_mem_cmd               o_mem_cmd,
    output logic [IDX_W-1:0]       o_rd_addr,
    output logic [IDX_W-1:0]       o_wr_addr,
    input  wire t_entry            i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } t_state;

    t_state            r_state,    n_state;
    logic              r_cmd,      n_cmd;
    logic [SIZE_W-1:0] r_size,     n_size;
    logic [ADDR_W-1:0] r_addr_in,  n_addr_in;
    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [CAP_W-1:0]  r_heap_top, n_heap_top;
    t_result           r_res,      n_res;

    logic              hit;
    logic              last;
    logic [CAP_W-1:0]  cap_eff;
    logic [NEED_W-1:0] need;
    logic [ADDR_W-1:0] new_start;

    // scan compare on the entry read last cycle
    assign hit  = (r_cmd == CMD_ALLOC)
                ? (i_rd_data.is_free && (i_rd_data.length >= r_size))
                : (i_rd_data.start == r_addr_in);
    assign last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // append arithmetic
    assign cap_eff   = (i_heap_cap > CAP_LIMIT) ? CAP_LIMIT : i_heap_cap;
    assign need      = NEED_W'(r_heap_top) + NEED_W'(HEADER_BYTES) + NEED_W'(r_size);
    assign new_start = ADDR_W'(NEED_W'(r_heap_top) + NEED_W'(HEADER_BYTES));

    // next state and table requests
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_size     = r_size;
        n_addr_in  = r_addr_in;
        n_idx      = r_idx;
        n_count    = r_count;
        n_heap_top = r_heap_top;
        n_res      = r_res;
        o_mem_cmd  = '0;
        o_rd_addr  = '0;
        o_wr_addr  = '0;
        o_res_valid = 1'b0;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_cmd;
                    n_size    = i_req_size;
                    n_addr_in = i_address;
                    n_idx     = '0;
                    n_res     = '{status: ST_OK, addr: '0};
                    if (i_cmd == CMD_ALLOC && i_req_size == '0) begin
                        n_res.status = ST_ZERO;
                        n_state      = S_DONE;
                    end else if (i_cmd == CMD_FREE && i_address == '0) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        if (i_cmd == CMD_ALLOC) begin
                            n_state = S_APPEND;
                        end else begin
                            n_res.status = ST_UNKNOWN;
                            n_state      = S_DONE;
                        end
                    end else begin
                        o_mem_cmd.rd_en = 1'b1;
                        o_rd_addr       = '0;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // reuse or release the matching block
                    o_mem_cmd.wr_en            = 1'b1;
                    o_mem_cmd.wr_entry         = i_rd_data;
                    o_mem_cmd.wr_entry.is_free = (r_cmd == CMD_FREE);
                    o_wr_addr                  = r_idx;
                    n_res.status = ST_OK;
                    n_res.addr   = (r_cmd == CMD_ALLOC) ? i_rd_data.start : '0;
                    n_state      = S_DONE;
                end else if (last) begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_state = S_APPEND;
                    end else begin
                        n_res.status = ST_UNKNOWN;
                        n_state      = S_DONE;
                    end
                end else begin
                    o_mem_cmd.rd_en = 1'b1;
                    o_rd_addr       = r_idx + IDX_W'(1);
                    n_idx           = r_idx + IDX_W'(1);
                end
            end
            S_APPEND: begin
                if (r_count >= CNT_W'(MAX_BLOCKS) || need > NEED_W'(cap_eff)) begin
                    n_res.status = ST_NOSPACE;
                end else begin
                    o_mem_cmd.wr_en    = 1'b1;
                    o_mem_cmd.wr_entry = '{start: new_start, length: r_size, is_free: 1'b0};
                    o_wr_addr          = IDX_W'(r_count);
                    n_count            = r_count + CNT_W'(1);
                    n_heap_top         = CAP_W'(need);
                    n_res.status       = ST_OK;
                    n_res.addr         = new_start;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = i_res_ready;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_heap_top <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_heap_top <= n_heap_top;
        end
        r_cmd     <= n_cmd;
        r_size    <= n_size;
        r_addr_in <= n_addr_in;
        r_idx     <= n_idx;
        r_res     <= n_res;
    end

    assign o_res = r_res;

    // checks
    `FFBA_ASSERT(a_no_write_idle, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> !o_mem_cmd.wr_en, "table write while idle")
    `FFBA_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_W'(MAX_BLOCKS), "block count above table depth")
    `FFBA_ASSERT(a_read_in_range, i_clk, i_rst_n,
        o_mem_cmd.rd_en |-> (CNT_W'(o_rd_addr) < r_count), "read beyond last block")
    `FFBA_ASSERT(a_scan_has_data, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> $past(o_mem_cmd.rd_en), "scan compare without a read")

endmodule

`default_nettype wire

### design/first_fit_block_allocator.sv
// sequence: a zero-size allocate, null free or free on an empty table goes straight to the result;
//   otherwise a scan of the entries ends on a match or an unknown address; an allocate with no
//   match, or on an empty table, then appends a new block (at most MAX_BLOCKS blocks)
// throughput: one command at a time; the next command is taken only once the last result is handed on
// reset: synchronous, active low; clears block count, heap top, control and capacity
//   (to 1048576); table contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap allocator over an append-only block table held in memory
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // req_size[19:0], address[39:20]
    input  wire logic [0:0]  s_axis_tuser,   // cmd[0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // address_res[19:0], status[21:20], zero[23:22]
    // heap capacity register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [20:0] i_cfg_data      // heap_capacity[20:0]
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic [CAP_W-1:0] r_heap_cap;
    logic             r_m_valid;
    t_result          r_m_res;

    logic             slot_free;
    logic             res_valid;
    t_result          res;
    t_mem_cmd         mem_cmd;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_entry           rd_data;

    // capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_heap_cap <= i_cfg_data;
        end
    end

    // sequencer
    ffba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser[0]),
        .i_req_size  (s_axis_tdata[19:0]),
        .i_address   (s_axis_tdata[39:20]),
        .i_heap_cap  (r_heap_cap),
        .o_res_valid (res_valid),
        .i_res_ready (slot_free),
        .o_res       (res),
        .o_mem_cmd   (mem_cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .i_rd_data   (rd_data)
    );

    // block table
    ffba_table #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_rd_data (rd_data)
    );

    // output register
    assign slot_free = !r_m_valid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_res.status, r_m_res.addr};

endmodule

`default_nettype wire
